[src/qvr_pkg.sv]
package qvr_pkg;

    // Field widths.
    localparam int QW  = 16;          // quaternion component, Q1.14
    localparam int VW  = 32;          // vector component, Q16.16
    localparam int PW  = 2 * QW;      // product of two quaternion components
    localparam int NW  = PW + 1;      // squared length, up to 2^32
    localparam int MW  = PW + 2;      // signed unnormalized matrix entry
    localparam int RQW = 31;          // quotient magnitude, at most 2^30
    localparam int FRAC = 30;         // fraction bits of a normalized entry
    localparam int DW  = 64;          // dividend width
    localparam int RW  = RQW + 1;     // signed normalized entry
    localparam int SW  = 64;          // matrix-vector sum width
    localparam int LANES = 9;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [LANES-1:0][MW-1:0] m;
        logic [NW-1:0]            n;
        logic [2:0][VW-1:0]       v;
        logic                     zero;
    } front_item_t;

endpackage

[src/qvr_front.sv]
module qvr_front
    import qvr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [QW-1:0]     quat_w,
    input  logic [QW-1:0]     quat_x,
    input  logic [QW-1:0]     quat_y,
    input  logic [QW-1:0]     quat_z,
    input  logic [VW-1:0]     vec_x,
    input  logic [VW-1:0]     vec_y,
    input  logic [VW-1:0]     vec_z,
    input  logic              q_full,
    output logic              q_push,
    output front_item_t       q_item
);

    logic                  f1_vld_reg;
    logic signed [PW-1:0]  ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0]  xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic [2:0][VW-1:0]    v1_reg;
    logic                  f2_vld_reg;
    front_item_t           item_reg;
    front_item_t           item_next;
    logic                  front_en;

    assign front_en = !f2_vld_reg || !q_full;
    assign in_stall = !front_en;
    assign q_push   = f2_vld_reg && !q_full;
    assign q_item   = item_reg;

    always_comb
    begin
        item_next.m[0] = MW'(ww_reg) + MW'(xx_reg) - MW'(yy_reg) - MW'(zz_reg);
        item_next.m[1] = (MW'(xy_reg) - MW'(wz_reg)) <<< 1;
        item_next.m[2] = (MW'(xz_reg) + MW'(wy_reg)) <<< 1;
        item_next.m[3] = (MW'(xy_reg) + MW'(wz_reg)) <<< 1;
        item_next.m[4] = MW'(ww_reg) - MW'(xx_reg) + MW'(yy_reg) - MW'(zz_reg);
        item_next.m[5] = (MW'(yz_reg) - MW'(wx_reg)) <<< 1;
        item_next.m[6] = (MW'(xz_reg) - MW'(wy_reg)) <<< 1;
        item_next.m[7] = (MW'(yz_reg) + MW'(wx_reg)) <<< 1;
        item_next.m[8] = MW'(ww_reg) - MW'(xx_reg) - MW'(yy_reg) + MW'(zz_reg);
        item_next.n    = NW'($unsigned(ww_reg)) + NW'($unsigned(xx_reg))
                       + NW'($unsigned(yy_reg)) + NW'($unsigned(zz_reg));
        item_next.v    = v1_reg;
        item_next.zero = (item_next.n == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (front_en)
        begin
            f1_vld_reg <= in_valid;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            ww_reg   <= $signed(quat_w) * $signed(quat_w);
            xx_reg   <= $signed(quat_x) * $signed(quat_x);
            yy_reg   <= $signed(quat_y) * $signed(quat_y);
            zz_reg   <= $signed(quat_z) * $signed(quat_z);
            xy_reg   <= $signed(quat_x) * $signed(quat_y);
            wz_reg   <= $signed(quat_w) * $signed(quat_z);
            xz_reg   <= $signed(quat_x) * $signed(quat_z);
            wy_reg   <= $signed(quat_w) * $signed(quat_y);
            yz_reg   <= $signed(quat_y) * $signed(quat_z);
            wx_reg   <= $signed(quat_w) * $signed(quat_x);
            v1_reg   <= {vec_z, vec_y, vec_x};
            item_reg <= item_next;
        end
    end

endmodule

[src/qvr_queue.sv]
module qvr_queue
    import qvr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  front_item_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output front_item_t pop_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    front_item_t    mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[src/qvr_back.sv]
module qvr_back
    import qvr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    output logic          q_pop,
    input  front_item_t   q_item,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [VW-1:0] rot_x,
    output logic [VW-1:0] rot_y,
    output logic [VW-1:0] rot_z,
    output logic          zero_quat_error
);

    localparam int ST = RQW + 1;

    logic                 back_en;

    // Divider pipeline, one quotient bit per stage and lane.
    logic                 d_vld_reg  [ST];
    logic [NW-1:0]        d_n_reg    [ST];
    logic [2:0][VW-1:0]   d_v_reg    [ST];
    logic                 d_zero_reg [ST];
    logic                 d_neg_reg  [ST][LANES];
    logic [NW-1:0]        d_rem_reg  [ST][LANES];
    logic [RQW-1:0]       d_low_reg  [ST][LANES];
    logic [RQW-1:0]       d_q_reg    [ST][LANES];

    logic                 r_vld_reg, p_vld_reg, s_vld_reg, o_vld_reg;
    logic                 r_zero_reg, p_zero_reg, s_zero_reg;
    logic [2:0][VW-1:0]   r_v_reg;
    logic signed [RW-1:0] r_reg [LANES];
    logic signed [SW-1:0] p_reg [LANES];
    logic signed [SW-1:0] s_reg [3];
    logic [VW-1:0]        o_reg [3];
    logic                 o_zero_reg;

    logic [NW-1:0]        n_div;
    logic [VW-1:0]        o_next [3];

    assign back_en = !(o_vld_reg && out_stall);
    assign q_pop   = back_en && !q_empty;
    assign n_div   = q_item.zero ? NW'(1) : q_item.n;

    always_comb
    begin
        logic [SW-1:0] mag;
        logic [SW-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            mag = s_reg[i][SW-1] ? SW'(-s_reg[i]) : SW'(s_reg[i]);
            q   = (mag + (SW'(1) << (FRAC - 1))) >> FRAC;
            if (s_zero_reg)
                o_next[i] = '0;
            else if (s_reg[i][SW-1])
                o_next[i] = (q > SW'(64'h8000_0000)) ? VW'(32'h8000_0000)
                                                      : VW'(-q);
            else
                o_next[i] = (q > SW'(64'h7FFF_FFFF)) ? VW'(32'h7FFF_FFFF)
                                                      : q[VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < ST; s++)
                d_vld_reg[s] <= 1'b0;
            r_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (back_en)
        begin
            d_vld_reg[0] <= !q_empty;
            for (int s = 1; s < ST; s++)
                d_vld_reg[s] <= d_vld_reg[s-1];
            r_vld_reg <= d_vld_reg[ST-1];
            p_vld_reg <= r_vld_reg;
            s_vld_reg <= p_vld_reg;
            o_vld_reg <= s_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [MW-1:0]  mv;
        logic [NW-1:0]  mag;
        logic [DW-1:0]  dvd;
        logic [NW:0]    t;
        logic           ge;
        if (back_en)
        begin
            // Dividend setup: |m| * 2^30 + n/2, magnitude first.
            d_n_reg[0]    <= n_div;
            d_v_reg[0]    <= q_item.v;
            d_zero_reg[0] <= q_item.zero;
            for (int l = 0; l < LANES; l++)
            begin
                mv  = q_item.m[l];
                mag = mv[MW-1] ? NW'(-mv) : NW'(mv);
                dvd = DW'({mag, {FRAC{1'b0}}}) + DW'(n_div[NW-1:1]);
                d_neg_reg[0][l] <= mv[MW-1];
                d_rem_reg[0][l] <= dvd[DW-1:RQW];
                d_low_reg[0][l] <= dvd[RQW-1:0];
                d_q_reg[0][l]   <= '0;
            end

            // Restoring division stages.
            for (int s = 1; s < ST; s++)
            begin
                d_n_reg[s]    <= d_n_reg[s-1];
                d_v_reg[s]    <= d_v_reg[s-1];
                d_zero_reg[s] <= d_zero_reg[s-1];
                for (int l = 0; l < LANES; l++)
                begin
                    t  = {d_rem_reg[s-1][l], d_low_reg[s-1][l][RQW-1]};
                    ge = (t >= {1'b0, d_n_reg[s-1]});
                    d_rem_reg[s][l] <= ge ? NW'(t - {1'b0, d_n_reg[s-1]}) : t[NW-1:0];
                    d_low_reg[s][l] <= d_low_reg[s-1][l] << 1;
                    d_q_reg[s][l]   <= {d_q_reg[s-1][l][RQW-2:0], ge};
                    d_neg_reg[s][l] <= d_neg_reg[s-1][l];
                end
            end

            // Signed normalized entries.
            r_v_reg    <= d_v_reg[ST-1];
            r_zero_reg <= d_zero_reg[ST-1];
            for (int l = 0; l < LANES; l++)
                r_reg[l] <= d_neg_reg[ST-1][l] ? -$signed({1'b0, d_q_reg[ST-1][l]})
                                               : $signed({1'b0, d_q_reg[ST-1][l]});

            // Entry times vector component.
            p_zero_reg <= r_zero_reg;
            for (int l = 0; l < LANES; l++)
                p_reg[l] <= r_reg[l] * $signed(r_v_reg[l % 3]);

            // Row sums.
            s_zero_reg <= p_zero_reg;
            for (int i = 0; i < 3; i++)
                s_reg[i] <= p_reg[3*i] + p_reg[3*i+1] + p_reg[3*i+2];

            // Rounding and saturation into the output register.
            o_zero_reg <= s_zero_reg;
            for (int i = 0; i < 3; i++)
                o_reg[i] <= o_next[i];
        end
    end

    assign out_valid       = o_vld_reg;
    assign rot_x           = o_reg[0];
    assign rot_y           = o_reg[1];
    assign rot_z           = o_reg[2];
    assign zero_quat_error = o_zero_reg;

endmodule

[src/quaternion_vector_rotate.sv]
// Quaternion vector rotation. Each item carries a quaternion (quat_w..quat_z,
// signed Q1.14, any nonzero length) and a vector (vec_x..vec_z, signed
// Q16.16); the block returns the vector rotated by the normalized quaternion,
// rounded to nearest and saturated to Q16.16. Normalization divides the nine
// entries of the unnormalized rotation matrix by the squared length, so no
// square root is needed. An all-zero quaternion gives a zero vector with
// zero_quat_error set. The block takes one item every cycle while in_stall is
// low and returns one result per item in order. The front part registers the
// component products, then the matrix entries and squared length; items then
// pass through the queue into the back part, whose depth is set by the
// pipelined dividers (a dividend setup stage, then one quotient bit per stage
// for each of nine lanes). The front and back are split by a small queue, so
// the front keeps accepting items after the output stalls, until the queue
// is full.
module quaternion_vector_rotate
    import qvr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [QW-1:0] quat_w,
    input  logic [QW-1:0] quat_x,
    input  logic [QW-1:0] quat_y,
    input  logic [QW-1:0] quat_z,
    input  logic [VW-1:0] vec_x,
    input  logic [VW-1:0] vec_y,
    input  logic [VW-1:0] vec_z,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [VW-1:0] rot_x,
    output logic [VW-1:0] rot_y,
    output logic [VW-1:0] rot_z,
    output logic          zero_quat_error
);

    logic        q_full, q_push, q_pop, q_empty;
    front_item_t push_item, pop_item;

    // Front: products of the quaternion components and the matrix entries.
    qvr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .quat_w   (quat_w),
        .quat_x   (quat_x),
        .quat_y   (quat_y),
        .quat_z   (quat_z),
        .vec_x    (vec_x),
        .vec_y    (vec_y),
        .vec_z    (vec_z),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    qvr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (pop_item)
    );

    // Back: normalization by division, matrix-vector product, rounding.
    qvr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .q_item          (pop_item),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rot_x           (rot_x),
        .rot_y           (rot_y),
        .rot_z           (rot_z),
        .zero_quat_error (zero_quat_error)
    );

endmodule

[test/tb_quaternion_vector_rotate.sv]
`timescale 1ns / 100ps

// Self-checking bench for the quaternion vector rotation block. Each item that
// the block accepts is run through a local predictor, and the expected rotated
// vector is queued. Every accepted result is compared against the oldest
// queued entry, field by field.
module tb_quaternion_vector_rotate;
    import qvr_pkg::*;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [QW-1:0] quat_w;
    logic [QW-1:0] quat_x;
    logic [QW-1:0] quat_y;
    logic [QW-1:0] quat_z;
    logic [VW-1:0] vec_x;
    logic [VW-1:0] vec_y;
    logic [VW-1:0] vec_z;
    logic          out_valid;
    logic          out_stall;
    logic [VW-1:0] rot_x;
    logic [VW-1:0] rot_y;
    logic [VW-1:0] rot_z;
    logic          zero_quat_error;

    // One expected result of the block.
    typedef struct {
        logic [VW-1:0] x;
        logic [VW-1:0] y;
        logic [VW-1:0] z;
        logic          err;
    } rotated_t;

    rotated_t rotated_pending[$];

    int error_count;
    int cycle_count;
    int send_idle_pct;
    int stall_pct;
    int hold_off_cycles;

    // The block is deeply pipelined with a small queue, so this settles it.
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    quaternion_vector_rotate uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .quat_w          (quat_w),
        .quat_x          (quat_x),
        .quat_y          (quat_y),
        .quat_z          (quat_z),
        .vec_x           (vec_x),
        .vec_y           (vec_y),
        .vec_z           (vec_z),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rot_x           (rot_x),
        .rot_y           (rot_y),
        .rot_z           (rot_z),
        .zero_quat_error (zero_quat_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Divide a matrix entry by the squared length, as Q1.30 rounded to
    // nearest with ties away from zero.
    function automatic longint normalize_entry(longint m, longint n);
        longint mag;
        longint q;
        mag = (m < 0) ? -m : m;
        q = ((mag <<< 30) + (n >>> 1)) / n;
        return (m < 0) ? -q : q;
    endfunction

    // Drop 30 fraction bits with rounding, then clamp to 32 bits signed.
    function automatic logic [VW-1:0] round_saturate(longint s);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (s < 0) ? 64'(-s) : 64'(s);
        q = (mag + (64'd1 << 29)) >> 30;
        if (s < 0)
        begin
            if (q > 64'h8000_0000)
                return 32'h8000_0000;
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF)
            return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic rotated_t rotate_vector(logic [QW-1:0] qw, logic [QW-1:0] qx,
                                               logic [QW-1:0] qy, logic [QW-1:0] qz,
                                               logic [VW-1:0] vx, logic [VW-1:0] vy,
                                               logic [VW-1:0] vz);
        rotated_t res;
        longint w, x, y, z, n, s;
        longint v[3];
        longint m[9];
        longint r[9];
        logic [VW-1:0] o[3];
        w = longint'($signed(qw));
        x = longint'($signed(qx));
        y = longint'($signed(qy));
        z = longint'($signed(qz));
        v[0] = longint'($signed(vx));
        v[1] = longint'($signed(vy));
        v[2] = longint'($signed(vz));
        n = w * w + x * x + y * y + z * z;
        if (n == 0)
        begin
            res.x = '0;
            res.y = '0;
            res.z = '0;
            res.err = 1'b1;
            return res;
        end
        m[0] = w * w + x * x - y * y - z * z;
        m[1] = 2 * (x * y - w * z);
        m[2] = 2 * (x * z + w * y);
        m[3] = 2 * (x * y + w * z);
        m[4] = w * w - x * x + y * y - z * z;
        m[5] = 2 * (y * z - w * x);
        m[6] = 2 * (x * z - w * y);
        m[7] = 2 * (y * z + w * x);
        m[8] = w * w - x * x - y * y + z * z;
        for (int i = 0; i < 9; i++)
            r[i] = normalize_entry(m[i], n);
        for (int i = 0; i < 3; i++)
        begin
            s = 0;
            for (int j = 0; j < 3; j++)
                s += r[i * 3 + j] * v[j];
            o[i] = round_saturate(s);
        end
        res.x = o[0];
        res.y = o[1];
        res.z = o[2];
        res.err = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
        error_count++;
        $display("Mismatch at cycle %0d on %s: got %h, expected %h",
                 cycle_count, what, got, want);
    endtask

    // Offer one item and hold it until the block takes it. The prediction is
    // queued at the accepting edge, so it always precedes the result. Valid
    // stays high on return so that the next item can follow directly; the
    // caller drops it when the stream pauses.
    task automatic send_item(logic [QW-1:0] qw, logic [QW-1:0] qx, logic [QW-1:0] qy,
                             logic [QW-1:0] qz, logic [VW-1:0] vx, logic [VW-1:0] vy,
                             logic [VW-1:0] vz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        quat_w <= qw;
        quat_x <= qx;
        quat_y <= qy;
        quat_z <= qz;
        vec_x <= vx;
        vec_y <= vy;
        vec_z <= vz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rotated_pending.push_back(rotate_vector(qw, qx, qy, qz, vx, vy, vz));
        @(negedge clk);
    endtask

    // Random quaternion: full-range in half the draws, else small, zeroed or
    // extreme components, so that normalization sees tiny lengths too.
    task automatic send_random_item();
        logic [QW-1:0] q[4];
        logic [VW-1:0] v[3];
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(5))
                0: q[i] = '0;
                1: q[i] = QW'($signed($urandom_range(6)) - 3);
                2: q[i] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
                default: q[i] = QW'($urandom);
            endcase
        end
        for (int i = 0; i < 3; i++)
        begin
            case ($urandom_range(4))
                0: v[i] = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                1: v[i] = VW'($signed($urandom_range(1 << 20)) - (1 << 19));
                default: v[i] = $urandom;
            endcase
        end
        send_item(q[0], q[1], q[2], q[3], v[0], v[1], v[2]);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (rotated_pending.size() != 0)
            @(negedge clk);
    endtask

    // Extremes of every field, the zero-length quaternion and saturation.
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        send_item(16'h4000, '0, '0, '0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_item('0, '0, '0, '0, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item('0, '0, '0, '0, '0, '0, '0);
        send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(16'h8000, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item('0, 16'h8000, '0, '0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item('0, '0, 16'h7FFF, '0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item('0, '0, '0, 16'h0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(16'h0001, 16'h0001, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
        // A 90 degree turn about z; the next one, about x, saturates y.
        send_item(16'h7FFF, '0, '0, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
        send_item(16'h7FFF, 16'h7FFF, '0, '0, '0, 32'h8000_0000, 32'h8000_0000);
        send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001);
        send_item(16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
        wait_until_drained();
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (count)
            send_random_item();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // The receiver holds off long enough for the pipeline and queue to fill
    // while items keep coming, then the sender waits out every result.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_cycles = 150;
        repeat (100)
            send_random_item();
        wait_until_drained();
    endtask

    // Receiver side: random stall, or a long counted hold-off when requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker: runs at every rising edge where a result is taken.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rotated_pending.size() == 0)
                report_mismatch("unexpected result", rot_x, '0);
            else
            begin
                rotated_t want;
                want = rotated_pending.pop_front();
                if (rot_x !== want.x)
                    report_mismatch("rot_x", rot_x, want.x);
                if (rot_y !== want.y)
                    report_mismatch("rot_y", rot_y, want.y);
                if (rot_z !== want.z)
                    report_mismatch("rot_z", rot_z, want.z);
                if (zero_quat_error !== want.err)
                    report_mismatch("zero_quat_error", VW'(zero_quat_error), VW'(want.err));
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        vec_x = '0;
        vec_y = '0;
        vec_z = '0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(500, 0, 0);
        test_random(450, 50, 0);
        test_random(450, 0, 50);
        test_random(450, 22, 22);
        test_backpressure();

        wait_until_drained();
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
src/qvr_pkg.sv
src/qvr_front.sv
src/qvr_queue.sv
src/qvr_back.sv
src/quaternion_vector_rotate.sv
test/tb_quaternion_vector_rotate.sv
